// ===== sv/lsti_pkg.sv =====
// Shared constants, method codes and scan job type for the scan timestamp imputer.
package lsti_pkg;

    localparam int MAX_COLS = 2048;
    localparam int CNT_W    = $clog2(MAX_COLS + 1);
    localparam int IDX_W    = $clog2(MAX_COLS);
    localparam int TS_W     = 64;
    localparam int SPC_W    = 34;
    localparam int PROD_W   = TS_W + CNT_W;
    localparam int SN_W     = CNT_W + 2;
    localparam int DCNT_W   = $clog2(PROD_W);

    localparam logic [SPC_W-1:0] SPACING_RESET = SPC_W'(64'd3200000000);

    localparam logic [1:0] METHOD_DIRECT = 2'd0;
    localparam logic [1:0] METHOD_EXTRAP = 2'd1;
    localparam logic [1:0] METHOD_INTERP = 2'd2;
    localparam logic [1:0] METHOD_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [TS_W-1:0]  first_value;
        logic [IDX_W-1:0] first_idx;
        logic [CNT_W-1:0] col_count;
        logic [IDX_W-1:0] prev_idx;
        logic [TS_W-1:0]  prev_value;
    } job_t;

endpackage

// ===== sv/lsti_front.sv =====
// Column tracker: finds first and last valid columns and issues one job per scan.
module lsti_front
    import lsti_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [TS_W-1:0] col_timestamp,
    input  logic            last_col,
    input  logic            q_full,
    output logic            q_push,
    output job_t            q_data
);

    logic             seen_reg, seen_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;
    logic [TS_W-1:0]  fval_reg, fval_next;
    logic [IDX_W-1:0] lidx_reg, lidx_next;
    logic [TS_W-1:0]  lval_reg, lval_next;
    logic [IDX_W-1:0] pidx_reg, pidx_next;
    logic [TS_W-1:0]  pval_reg, pval_next;

    logic             accept;
    logic             in_range;
    logic             hit;
    logic             found_e;
    logic [IDX_W-1:0] fidx_e;
    logic [TS_W-1:0]  fval_e;
    logic [IDX_W-1:0] lidx_e;
    logic [TS_W-1:0]  lval_e;
    logic [CNT_W-1:0] cnt_e;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        in_range = cnt_reg < CNT_W'(MAX_COLS);
        hit      = in_range && (col_timestamp != '0);
        found_e  = found_reg || hit;
        fidx_e   = (!found_reg && hit) ? cnt_reg[IDX_W-1:0] : fidx_reg;
        fval_e   = (!found_reg && hit) ? col_timestamp : fval_reg;
        lidx_e   = hit ? cnt_reg[IDX_W-1:0] : lidx_reg;
        lval_e   = hit ? col_timestamp : lval_reg;
        cnt_e    = in_range ? cnt_reg + CNT_W'(1) : cnt_reg;

        q_data.first_value = fval_e;
        q_data.first_idx   = fidx_e;
        q_data.col_count   = cnt_e;
        q_data.prev_idx    = pidx_reg;
        q_data.prev_value  = pval_reg;
        if (!found_e)
            q_data.kind = METHOD_EMPTY;
        else if (fidx_e == '0)
            q_data.kind = METHOD_DIRECT;
        else if (!seen_reg)
            q_data.kind = METHOD_EXTRAP;
        else
            q_data.kind = METHOD_INTERP;

        q_push = accept && last_col;

        seen_next  = seen_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        fidx_next  = fidx_reg;
        fval_next  = fval_reg;
        lidx_next  = lidx_reg;
        lval_next  = lval_reg;
        pidx_next  = pidx_reg;
        pval_next  = pval_reg;
        if (accept)
        begin
            if (last_col)
            begin
                cnt_next   = '0;
                found_next = 1'b0;
                fidx_next  = '0;
                fval_next  = '0;
                lidx_next  = '0;
                lval_next  = '0;
                if (found_e)
                begin
                    seen_next = 1'b1;
                    pidx_next = lidx_e;
                    pval_next = lval_e;
                end
            end
            else
            begin
                cnt_next   = cnt_e;
                found_next = found_e;
                fidx_next  = fidx_e;
                fval_next  = fval_e;
                lidx_next  = lidx_e;
                lval_next  = lval_e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            fidx_reg  <= '0;
            fval_reg  <= '0;
            lidx_reg  <= '0;
            lval_reg  <= '0;
            pidx_reg  <= '0;
            pval_reg  <= '0;
        end
        else
        begin
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
            fidx_reg  <= fidx_next;
            fval_reg  <= fval_next;
            lidx_reg  <= lidx_next;
            lval_reg  <= lval_next;
            pidx_reg  <= pidx_next;
            pval_reg  <= pval_next;
        end
    end

endmodule

// ===== sv/lsti_jobq.sv =====
// Two-entry queue of scan jobs between the column tracker and the solver.
module lsti_jobq
    import lsti_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t rdata
);

    job_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next = do_push ? !wptr_reg : wptr_reg;
        rptr_next = do_pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== sv/lsti_back.sv =====
// Scan start solver: multiply, bit-serial divide, round and clamp, result register.
module lsti_back
    import lsti_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SPC_W-1:0] spacing,
    input  logic             q_empty,
    input  job_t             q_data,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output logic [TS_W-1:0]  scan_ts,
    output logic [1:0]       method
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [TS_W-1:0] TS_MAX = '1;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [TS_W-1:0]   y0_reg, y0_next;
    logic [TS_W-1:0]   y1_reg, y1_next;
    logic              up_reg, up_next;
    logic              spec_d_reg, spec_d_next;
    logic              spec_n_reg, spec_n_next;
    logic [TS_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0]  b_reg, b_next;
    logic [CNT_W-1:0]  d_reg, d_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0] step_reg, step_next;
    logic              oval_reg, oval_next;
    logic [TS_W-1:0]   ots_reg, ots_next;
    logic [1:0]        omth_reg, omth_next;

    logic signed [SN_W-1:0] n_s;
    logic signed [SN_W-1:0] d_s;
    logic [SN_W-1:0]        abs_n;
    logic                   gt;
    logic [TS_W-1:0]        delta;
    logic [CNT_W:0]         trial;
    logic                   fit;
    logic [TS_W-1:0]        q_sat;
    logic [TS_W:0]          sum;
    logic [TS_W-1:0]        q_dn;
    logic [TS_W-1:0]        whole;
    logic [TS_W-1:0]        t_ex;
    logic [TS_W-1:0]        res;
    logic                   slot_free;

    assign empty     = !oval_reg;
    assign scan_ts   = ots_reg;
    assign method    = omth_reg;
    assign slot_free = !oval_reg || pop;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        n_s   = $signed({2'b0, q_data.col_count}) - $signed({3'b0, q_data.prev_idx});
        d_s   = n_s + $signed({3'b0, q_data.first_idx});
        abs_n = n_s[SN_W-1] ? SN_W'(-n_s) : SN_W'(n_s);
        gt    = q_data.first_value > q_data.prev_value;
        delta = gt ? q_data.first_value - q_data.prev_value
                   : q_data.prev_value - q_data.first_value;

        trial = {rem_reg, prod_reg[PROD_W-1]};
        fit   = trial >= {1'b0, d_reg};

        q_sat = (prod_reg[PROD_W-1:TS_W] != '0) ? TS_MAX : prod_reg[TS_W-1:0];
        sum   = {1'b0, y0_reg} + {1'b0, q_sat};
        q_dn  = ((rem_reg != '0) && (q_sat != TS_MAX)) ? q_sat + TS_W'(1) : q_sat;
        whole = TS_W'(prod_reg >> 16);
        t_ex  = (y1_reg < whole) ? '0 : y1_reg - whole;
        if ((y1_reg >= whole) && (prod_reg[15:0] > 16'h8000) && (t_ex != '0))
            t_ex = t_ex - TS_W'(1);

        case (kind_reg)
            METHOD_EXTRAP: res = t_ex;
            METHOD_INTERP:
            begin
                if (spec_d_reg)
                    res = y1_reg;
                else if (spec_n_reg)
                    res = y0_reg;
                else if (up_reg)
                    res = sum[TS_W] ? TS_MAX : sum[TS_W-1:0];
                else
                    res = (y0_reg >= q_dn) ? y0_reg - q_dn : '0;
            end
            default: res = y1_reg;
        endcase

        state_next  = state_reg;
        kind_next   = kind_reg;
        y0_next     = y0_reg;
        y1_next     = y1_reg;
        up_next     = up_reg;
        spec_d_next = spec_d_reg;
        spec_n_next = spec_n_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        d_next      = d_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        oval_next   = oval_reg && !pop;
        ots_next    = ots_reg;
        omth_next   = omth_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    kind_next   = q_data.kind;
                    y0_next     = q_data.prev_value;
                    y1_next     = q_data.first_value;
                    up_next     = gt ^ n_s[SN_W-1];
                    spec_d_next = d_s[SN_W-1] || (d_s == '0);
                    spec_n_next = n_s == '0;
                    d_next      = d_s[CNT_W-1:0];
                    if (q_data.kind == METHOD_EXTRAP)
                    begin
                        a_next = TS_W'(spacing);
                        b_next = CNT_W'(q_data.first_idx);
                    end
                    else
                    begin
                        a_next = delta;
                        b_next = abs_n[CNT_W-1:0];
                    end
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next = PROD_W'(a_reg) * PROD_W'(b_reg);
                rem_next  = '0;
                step_next = '0;
                if ((kind_reg == METHOD_INTERP) && !spec_d_reg && !spec_n_reg)
                    state_next = S_DIV;
                else
                    state_next = S_FIN;
            end
            S_DIV:
            begin
                rem_next  = fit ? CNT_W'(trial - {1'b0, d_reg}) : trial[CNT_W-1:0];
                prod_next = {prod_reg[PROD_W-2:0], fit};
                step_next = step_reg + DCNT_W'(1);
                if (step_reg == DCNT_W'(PROD_W - 1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    oval_next  = 1'b1;
                    ots_next   = (kind_reg == METHOD_EMPTY) ? '0 : res;
                    omth_next  = kind_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        y0_reg     <= y0_next;
        y1_reg     <= y1_next;
        up_reg     <= up_next;
        spec_d_reg <= spec_d_next;
        spec_n_reg <= spec_n_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        d_reg      <= d_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        ots_reg    <= ots_next;
        omth_reg   <= omth_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

// ===== sv/lidar_scan_timestamp_impute.sv =====
// Scan start timestamp imputer: top level with spacing register, tracker, job queue, solver.
// Columns are taken one per cycle while the two-entry job queue has room; a column
// that ends a scan queues one job. The solver handles one job at a time: a direct,
// empty or extrapolated scan goes from idle through multiply and finish to the result
// register, as does an interpolated scan whose span is not positive or whose previous
// last column sits at the scan width. Any other interpolated scan also goes through the
// bit-serial divider, retiring one quotient bit of the 76-bit product per cycle. A finished
// job waits in the solver until the one-word output register is free, so a slow
// reader stalls the solver. full follows the job queue: it rises when scans end faster
// than they are solved or their results are not taken, and while it is high no column
// is taken, not only the last one of a scan.
module lidar_scan_timestamp_impute
    import lsti_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [SPC_W-1:0] cfg_wr_data,
    input  logic             push,
    output logic             full,
    input  logic [TS_W-1:0]  col_timestamp,
    input  logic             last_col,
    output logic             empty,
    input  logic             pop,
    output logic [TS_W-1:0]  scan_ts,
    output logic [1:0]       method
);

    logic [SPC_W-1:0] spacing_reg;
    logic             jq_push;
    logic             jq_full;
    logic             jq_pop;
    logic             jq_empty;
    job_t             jq_wdata;
    job_t             jq_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            spacing_reg <= SPACING_RESET;
        else if (cfg_wr_en)
            spacing_reg <= cfg_wr_data;
    end

    lsti_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .col_timestamp (col_timestamp),
        .last_col      (last_col),
        .q_full        (jq_full),
        .q_push        (jq_push),
        .q_data        (jq_wdata)
    );

    lsti_jobq u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (jq_push),
        .wdata (jq_wdata),
        .full  (jq_full),
        .pop   (jq_pop),
        .empty (jq_empty),
        .rdata (jq_rdata)
    );

    lsti_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .spacing (spacing_reg),
        .q_empty (jq_empty),
        .q_data  (jq_rdata),
        .q_pop   (jq_pop),
        .empty   (empty),
        .pop     (pop),
        .scan_ts (scan_ts),
        .method  (method)
    );

endmodule
